@@ hw/rtl/swer_pkg.sv @@
// Shared constants for the sliding window event rate unit.
`default_nettype none
package swer_pkg;

  // Register file layout
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_SPAN = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TPS      = 2'd2;

  // Register and result widths
  localparam int WIN_W     = 48;
  localparam int MIN_W     = 32;
  localparam int TPS_W     = 32;
  localparam int RATE_W    = 48;
  localparam int FRAC_BITS = 8;

  localparam logic [WIN_W-1:0]  WINDOW_RST   = 48'd1000000;
  localparam logic [MIN_W-1:0]  MIN_SPAN_RST = 32'd1;
  localparam logic [TPS_W-1:0]  TPS_RST      = 32'd1000000;
  localparam logic [RATE_W-1:0] RATE_MAX     = {RATE_W{1'b1}};

  // Request kinds
  localparam logic REQ_EVENT = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

endpackage
`default_nettype wire

@@ hw/rtl/sliding_window_event_rate_unit.sv @@
// Each request first evicts stale entries, a read and a compare step per entry; an
// event then writes its stamp, and a query with two or more entries adds a span step,
// a check and, unless the span is short, a divide of NUM_W (48 at DEPTH 256) bits. One
// item at a time; the one-bit-per-cycle divider and single ring read port set the rate.
// Reset (rst_n, synchronous) clears the sequencer, ring pointers, count, overflow flag
// and output valid flag, and restores register defaults; ring contents stay undefined.
`default_nettype none
module sliding_window_event_rate_unit
  import swer_pkg::*;
#(
  parameter int DEPTH     = 256,
  parameter int TIME_BITS = 48,
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire logic                  in_req_type,
  input  wire logic [TIME_BITS-1:0]  in_time_ticks,
  // result channel
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      logic                  out_rate_valid,
  output      logic [RATE_W-1:0]     out_rate_q8,
  output      logic [CNT_W-1:0]      out_event_count,
  output      logic                  out_overflowed,
  // register port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output      logic [CFG_DATA_W-1:0] prdata,
  output      logic                  pready
);

  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W = IDX_W + TPS_W;
  localparam int NUM_W  = PROD_W + FRAC_BITS;
  localparam int AGE_W  = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;
  localparam int SPN_W  = (TIME_BITS > MIN_W) ? TIME_BITS : MIN_W;
  localparam int QX_W   = (NUM_W > RATE_W) ? NUM_W : RATE_W + 1;

  localparam int STATE_W = 4;
  localparam logic [STATE_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [STATE_W-1:0] ST_EV_RD  = 4'd1;
  localparam logic [STATE_W-1:0] ST_EV_CMP = 4'd2;
  localparam logic [STATE_W-1:0] ST_ACT    = 4'd3;
  localparam logic [STATE_W-1:0] ST_SPAN   = 4'd4;
  localparam logic [STATE_W-1:0] ST_CHK    = 4'd5;
  localparam logic [STATE_W-1:0] ST_DIV    = 4'd6;
  localparam logic [STATE_W-1:0] ST_DONE   = 4'd7;

  // (base + off) modulo DEPTH, both operands below DEPTH
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // ---------------------------------------------------------------- registers
  logic [WIN_W-1:0] window_r;
  logic [MIN_W-1:0] min_span_r;
  logic [TPS_W-1:0] tps_r;

  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[CFG_ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= WINDOW_RST;
      min_span_r <= MIN_SPAN_RST;
      tps_r      <= TPS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WINDOW:   window_r   <= pwdata[WIN_W-1:0];
        REG_MIN_SPAN: min_span_r <= pwdata[MIN_W-1:0];
        REG_TPS:      tps_r      <= pwdata[TPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WINDOW:   prdata = CFG_DATA_W'(window_r);
      REG_MIN_SPAN: prdata = CFG_DATA_W'(min_span_r);
      REG_TPS:      prdata = CFG_DATA_W'(tps_r);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- sequencer state
  logic [STATE_W-1:0]   state_r,     state_nxt;
  logic                 kind_r;
  logic [TIME_BITS-1:0] now_r;
  logic [IDX_W-1:0]     oldest_r,    oldest_nxt;
  logic [CNT_W-1:0]     count_r,     count_nxt;
  logic                 ovf_r,       ovf_nxt;
  logic [TIME_BITS-1:0] old_stamp_r;
  logic [TIME_BITS-1:0] span_r;
  logic [NUM_W-1:0]     num_r;
  logic                 res_valid_r, res_valid_nxt;
  logic [RATE_W-1:0]    res_rate_r,  res_rate_nxt;

  logic                 out_valid_r,      out_valid_nxt;
  logic                 out_rate_valid_r;
  logic [RATE_W-1:0]    out_rate_q8_r;
  logic [CNT_W-1:0]     out_event_count_r;
  logic                 out_ovf_r;
  logic                 out_load;

  // ring and divider hookup
  logic                 ring_we;
  logic [IDX_W-1:0]     ring_waddr;
  logic                 ring_re;
  logic [IDX_W-1:0]     ring_raddr;
  logic [TIME_BITS-1:0] ring_rdata;
  logic                 div_start;
  logic                 div_done;
  logic [NUM_W-1:0]     div_quot;

  // datapath terms
  logic [TIME_BITS-1:0] age;
  logic                 too_old;
  logic [IDX_W-1:0]     oldest_inc;
  logic [IDX_W-1:0]     cnt_m1;
  logic                 ring_full;
  logic [PROD_W-1:0]    prod;
  logic                 span_short;
  logic [RATE_W-1:0]    rate_sat;
  logic                 in_xfer;

  assign in_xfer    = in_valid && !in_stall;
  assign age        = now_r - ring_rdata;
  assign too_old    = AGE_W'(age) > AGE_W'(window_r);
  assign oldest_inc = (oldest_r == IDX_W'(DEPTH - 1)) ? '0 : oldest_r + IDX_W'(1);
  assign cnt_m1     = IDX_W'(count_r - CNT_W'(1));
  assign ring_full  = (count_r == CNT_W'(DEPTH));
  assign prod       = PROD_W'(cnt_m1) * PROD_W'(tps_r);
  assign span_short = (span_r == '0) || (SPN_W'(span_r) < SPN_W'(min_span_r));
  assign rate_sat   = (QX_W'(div_quot) > QX_W'(RATE_MAX)) ? RATE_MAX : RATE_W'(div_quot);

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    res_valid_nxt = res_valid_r;
    res_rate_nxt  = res_rate_r;
    ring_we       = 1'b0;
    ring_waddr    = wrap_add(oldest_r, count_r[IDX_W-1:0]);
    ring_re       = 1'b0;
    ring_raddr    = oldest_r;
    div_start     = 1'b0;
    out_load      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_EV_RD;
        end
      end
      ST_EV_RD: begin
        if (count_r == '0) begin
          state_nxt = ST_ACT;
        end else begin
          ring_re   = 1'b1;
          state_nxt = ST_EV_CMP;
        end
      end
      ST_EV_CMP: begin
        if (too_old) begin
          // drop the oldest entry and look at the next one
          oldest_nxt = oldest_inc;
          count_nxt  = count_r - CNT_W'(1);
          state_nxt  = ST_EV_RD;
        end else begin
          state_nxt = ST_ACT;
        end
      end
      ST_ACT: begin
        if (kind_r == REQ_EVENT) begin
          ring_we = 1'b1;
          if (ring_full) begin
            // overwrite the oldest slot and advance past it
            ring_waddr = oldest_r;
            oldest_nxt = oldest_inc;
            ovf_nxt    = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
          state_nxt = ST_IDLE;
        end else if (count_r == '0) begin
          res_valid_nxt = 1'b0;
          res_rate_nxt  = '0;
          state_nxt     = ST_DONE;
        end else if (count_r == CNT_W'(1)) begin
          res_valid_nxt = 1'b1;
          res_rate_nxt  = '0;
          state_nxt     = ST_DONE;
        end else begin
          ring_re    = 1'b1;
          ring_raddr = wrap_add(oldest_r, cnt_m1);
          state_nxt  = ST_SPAN;
        end
      end
      ST_SPAN: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        res_valid_nxt = 1'b1;
        if (span_short) begin
          res_rate_nxt = '0;
          state_nxt    = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_rate_nxt = rate_sat;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output stage is free
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      oldest_r    <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_valid_r <= res_valid_nxt;
    res_rate_r  <= res_rate_nxt;
    if (in_xfer) begin
      kind_r <= in_req_type;
      now_r  <= in_time_ticks;
    end
    if (state_r == ST_EV_CMP && !too_old) begin
      old_stamp_r <= ring_rdata;
    end
    if (state_r == ST_SPAN) begin
      span_r <= ring_rdata - old_stamp_r;
      num_r  <= {prod, FRAC_BITS'(0)};
    end
    if (out_load) begin
      out_rate_valid_r  <= res_valid_r;
      out_rate_q8_r     <= res_rate_r;
      out_event_count_r <= count_r;
      out_ovf_r         <= ovf_r;
    end
  end

  swer_ring #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_waddr),
    .wr_data (now_r),
    .rd_en   (ring_re),
    .rd_addr (ring_raddr),
    .rd_data (ring_rdata)
  );

  swer_div #(
    .N_W (NUM_W),
    .D_W (TIME_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (span_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_rate_valid  = out_rate_valid_r;
  assign out_rate_q8     = out_rate_q8_r;
  assign out_event_count = out_event_count_r;
  assign out_overflowed  = out_ovf_r;

  // ---------------------------------------------------------------- assertions
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above ring depth");

  a_new_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result transfer started outside the done step");

  a_empty_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_rate_valid_r |-> out_rate_q8_r == '0 && out_event_count_r == '0)
    else $error("empty window reported a rate or a count");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide step");

endmodule
`default_nettype wire

@@ hw/rtl/swer_ring.sv @@
// Timestamp ring memory: one write port, one registered read port.
`default_nettype none
module swer_ring #(
  parameter int DEPTH     = 256,
  parameter int TIME_BITS = 48,
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [IDX_W-1:0]     wr_addr,
  input  wire logic [TIME_BITS-1:0] wr_data,
  input  wire logic                 rd_en,
  input  wire logic [IDX_W-1:0]     rd_addr,
  output      logic [TIME_BITS-1:0] rd_data
);

  logic [TIME_BITS-1:0] ring_r [DEPTH];
  logic [TIME_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ring_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ hw/rtl/swer_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module swer_div #(
  parameter int N_W = 48,
  parameter int D_W = 48
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [N_W-1:0] num,
  input  wire logic [D_W-1:0] den,
  output      logic           done,
  output      logic [N_W-1:0] quot
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [D_W-1:0]   rem_r;
  logic [N_W-1:0]   quo_r;
  logic [D_W-1:0]   den_r;

  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             fits;
  logic [D_W-1:0]   rem_nxt;
  logic [N_W-1:0]   quo_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[N_W-1]};
    diff    = trial - {1'b0, den_r};
    fits    = (trial >= {1'b0, den_r});
    // a failed trial stays below den, so its top bit is clear
    rem_nxt = fits ? diff[D_W-1:0] : trial[D_W-1:0];
    quo_nxt = {quo_r[N_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(N_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule
`default_nettype wire
